// ===== rtl/bcca_pkg.sv =====
// Shared types and constants for the bit column count / argmax unit.
// Used by bcca_lane, bcca_merge and bit_column_count_argmax_unit; no dependencies.
package bcca_pkg;

  localparam int SIDE        = 8;
  localparam int COUNT_WIDTH = 32;
  localparam int NELEM       = SIDE * SIDE;
  localparam int VEC_WIDTH   = 64;
  localparam int INDEX_WIDTH = 6;

  // One lane per row of SIDE elements.
  localparam int NLANES      = SIDE;
  localparam int LANE_ELEMS  = SIDE;
  localparam int LANE_IDX_W  = $clog2(LANE_ELEMS);
  localparam int MERGE_IDX_W = $clog2(NLANES);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SUB   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LANE,
    ST_MERGE
  } state_t;

  typedef struct packed {
    logic add;
    logic sub;
    logic query;
  } lane_ctrl_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] val;
    logic [LANE_IDX_W-1:0]  idx;
  } lane_best_t;

endpackage

// ===== rtl/bit_column_count_argmax_unit.sv =====
// Top level of the bit column count / argmax unit: command port, lanes and merge.
// Depends on bcca_pkg, bcca_lane and bcca_merge.
//
// Usage:
//   An item transfers at a rising edge where start is high and busy is low.
//   opcode add / subtract bumps the saturating counter of every element whose
//   bit is set in bit_vector (element i is bit 63-i); counters update at the
//   transfer edge and give no result. Opcode 3 does nothing.
//   A query registers exclude_mask; in the next cycle each of the eight lanes
//   reduces its eight counters to a local winner, and in the cycle after the
//   merge stage picks the overall winner. done is registered from the merge
//   stage and stays high for one cycle, with heaviest_index and found valid.
//   The receiver cannot stall: results are taken in the cycle done is high.
//   busy is high only in the cycle after a query transfer, in the lane tree
//   stage, and no command is taken then; a new query may transfer in the merge
//   cycle; add and subtract at one per cycle unless busy, also in that cycle.
//   Reset (rst, synchronous) clears all counters and returns to idle.
module bit_column_count_argmax_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          opcode,
  input  logic [bcca_pkg::VEC_WIDTH-1:0]      bit_vector,
  input  logic [bcca_pkg::VEC_WIDTH-1:0]      exclude_mask,
  output logic                                done,
  output logic [bcca_pkg::INDEX_WIDTH-1:0]    heaviest_index,
  output logic                                found
);

  bcca_pkg::state_t      state, state_next;
  bcca_pkg::lane_ctrl_t  ctrl;
  bcca_pkg::lane_best_t  lane_best [bcca_pkg::NLANES];
  logic [bcca_pkg::NELEM-1:0]       excl_q;
  logic [bcca_pkg::LANE_ELEMS-1:0]  vec_lane  [bcca_pkg::NLANES];
  logic [bcca_pkg::LANE_ELEMS-1:0]  excl_lane [bcca_pkg::NLANES];
  logic accept;
  logic is_query;

  assign accept   = start && !busy;
  assign is_query = (opcode == bcca_pkg::OP_QUERY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcca_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    unique case (state)
      bcca_pkg::ST_IDLE: begin
        if (accept && is_query) state_next = bcca_pkg::ST_LANE;
      end
      bcca_pkg::ST_LANE: begin
        busy       = 1'b1;
        state_next = bcca_pkg::ST_MERGE;
      end
      bcca_pkg::ST_MERGE: begin
        state_next = (accept && is_query) ? bcca_pkg::ST_LANE : bcca_pkg::ST_IDLE;
      end
      default: begin
        state_next = bcca_pkg::ST_IDLE;
      end
    endcase
  end

  assign ctrl.add   = accept && (opcode == bcca_pkg::OP_ADD);
  assign ctrl.sub   = accept && (opcode == bcca_pkg::OP_SUB);
  assign ctrl.query = (state == bcca_pkg::ST_LANE);

  // Hold the exclusion mask for the lane stage.
  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      excl_q <= exclude_mask[bcca_pkg::NELEM-1:0];
    end
  end

  for (genvar l = 0; l < bcca_pkg::NLANES; l++) begin : g_lane
    for (genvar k = 0; k < bcca_pkg::LANE_ELEMS; k++) begin : g_bit
      assign vec_lane[l][k]  = bit_vector[bcca_pkg::NELEM-1-(l*bcca_pkg::LANE_ELEMS+k)];
      assign excl_lane[l][k] = excl_q[bcca_pkg::NELEM-1-(l*bcca_pkg::LANE_ELEMS+k)];
    end
    bcca_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .vec  (vec_lane[l]),
      .excl (excl_lane[l]),
      .best (lane_best[l])
    );
  end

  bcca_merge u_merge (
    .clk            (clk),
    .rst            (rst),
    .go             (state == bcca_pkg::ST_MERGE),
    .lane_best      (lane_best),
    .done           (done),
    .heaviest_index (heaviest_index),
    .found          (found)
  );

  a_done_after_merge: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == bcca_pkg::ST_MERGE))
    else $error("done without a merge cycle");

  a_query_result: assert property (@(posedge clk) disable iff (rst)
    (accept && is_query) |-> ##3 done)
    else $error("query transfer did not produce a result");

  a_not_found_index: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (heaviest_index == '0))
    else $error("index nonzero when nothing found");

  a_busy_single: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

endmodule

// ===== rtl/bcca_lane.sv =====
// One lane: the saturating counters of one row of elements and the local argmax tree.
// Depends on bcca_pkg.
module bcca_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  bcca_pkg::lane_ctrl_t                ctrl,
  input  logic [bcca_pkg::LANE_ELEMS-1:0]     vec,
  input  logic [bcca_pkg::LANE_ELEMS-1:0]     excl,
  output bcca_pkg::lane_best_t                best
);

  localparam int TREE_N = 1 << bcca_pkg::LANE_IDX_W;

  logic [bcca_pkg::COUNT_WIDTH-1:0] counts [bcca_pkg::LANE_ELEMS];

  logic [bcca_pkg::COUNT_WIDTH-1:0] tv [0:bcca_pkg::LANE_IDX_W][0:TREE_N-1];
  logic [bcca_pkg::LANE_IDX_W-1:0]  ti [0:bcca_pkg::LANE_IDX_W][0:TREE_N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < bcca_pkg::LANE_ELEMS; k++) begin
        counts[k] <= '0;
      end
    end else begin
      for (int k = 0; k < bcca_pkg::LANE_ELEMS; k++) begin
        if (ctrl.add && vec[k] && counts[k] != bcca_pkg::COUNT_MAX) begin
          counts[k] <= counts[k] + 1'b1;
        end else if (ctrl.sub && vec[k] && counts[k] != '0) begin
          counts[k] <= counts[k] - 1'b1;
        end
      end
    end
  end

  // Excluded elements enter the tree as zero; the upper one of a pair wins only
  // when strictly larger, so ties go to the lower element.
  always_comb begin
    for (int l = 0; l <= bcca_pkg::LANE_IDX_W; l++) begin
      for (int n = 0; n < TREE_N; n++) begin
        tv[l][n] = '0;
        ti[l][n] = '0;
      end
    end
    for (int k = 0; k < bcca_pkg::LANE_ELEMS; k++) begin
      tv[0][k] = excl[k] ? '0 : counts[k];
      ti[0][k] = bcca_pkg::LANE_IDX_W'(k);
    end
    for (int l = 1; l <= bcca_pkg::LANE_IDX_W; l++) begin
      for (int n = 0; n < (TREE_N >> l); n++) begin
        if (tv[l-1][2*n+1] > tv[l-1][2*n]) begin
          tv[l][n] = tv[l-1][2*n+1];
          ti[l][n] = ti[l-1][2*n+1];
        end else begin
          tv[l][n] = tv[l-1][2*n];
          ti[l][n] = ti[l-1][2*n];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.query) begin
      best.val <= tv[bcca_pkg::LANE_IDX_W][0];
      best.idx <= ti[bcca_pkg::LANE_IDX_W][0];
    end
  end

endmodule

// ===== rtl/bcca_merge.sv =====
// Merge stage: picks the heaviest of the lane winners and registers the result.
// Depends on bcca_pkg.
module bcca_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                go,
  input  bcca_pkg::lane_best_t                lane_best [bcca_pkg::NLANES],
  output logic                                done,
  output logic [bcca_pkg::INDEX_WIDTH-1:0]    heaviest_index,
  output logic                                found
);

  localparam int MTREE_N = 1 << bcca_pkg::MERGE_IDX_W;

  logic [bcca_pkg::COUNT_WIDTH-1:0] mv [0:bcca_pkg::MERGE_IDX_W][0:MTREE_N-1];
  logic [bcca_pkg::INDEX_WIDTH-1:0] mi [0:bcca_pkg::MERGE_IDX_W][0:MTREE_N-1];
  logic [bcca_pkg::COUNT_WIDTH-1:0] top_val;
  logic [bcca_pkg::INDEX_WIDTH-1:0] top_idx;

  always_comb begin
    for (int l = 0; l <= bcca_pkg::MERGE_IDX_W; l++) begin
      for (int n = 0; n < MTREE_N; n++) begin
        mv[l][n] = '0;
        mi[l][n] = '0;
      end
    end
    // Element number is lane * SIDE + local index.
    for (int n = 0; n < bcca_pkg::NLANES; n++) begin
      mv[0][n] = lane_best[n].val;
      mi[0][n] = bcca_pkg::INDEX_WIDTH'(n * bcca_pkg::LANE_ELEMS)
               + bcca_pkg::INDEX_WIDTH'(lane_best[n].idx);
    end
    for (int l = 1; l <= bcca_pkg::MERGE_IDX_W; l++) begin
      for (int n = 0; n < (MTREE_N >> l); n++) begin
        if (mv[l-1][2*n+1] > mv[l-1][2*n]) begin
          mv[l][n] = mv[l-1][2*n+1];
          mi[l][n] = mi[l-1][2*n+1];
        end else begin
          mv[l][n] = mv[l-1][2*n];
          mi[l][n] = mi[l-1][2*n];
        end
      end
    end
    top_val = mv[bcca_pkg::MERGE_IDX_W][0];
    top_idx = mi[bcca_pkg::MERGE_IDX_W][0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      found          <= (top_val != '0);
      heaviest_index <= (top_val != '0) ? top_idx : '0;
    end
  end

endmodule
